FILE: hdl/gsse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsse_pkg
// Shared constants and types for the GF(2) system solution enumerator.
// ----------------------------------------------------------------------------
package gsse_pkg;

  // Row capacity (number of cells) and variable bits per row
  localparam int unsigned MAX_ROWS = 8;
  localparam int unsigned VAR_BITS = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BIT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] VAR_COUNT_RST = 3'd3;

  // Candidate token travelling down the cell chain
  typedef struct packed {
    logic                vld;
    logic [VAR_BITS-1:0] x;
    logic                ok;
    logic                last;
  } token_t;

endpackage
`default_nettype wire

FILE: hdl/gsse_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsse_cell
// One equation cell: holds a row, checks the passing candidate against it.
// ----------------------------------------------------------------------------
module gsse_cell (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               load_i,
  input  wire                               clear_i,
  input  wire  [gsse_pkg::VAR_BITS-1:0]     row_i,
  input  wire                               act_i,
  output logic [gsse_pkg::VAR_BITS-1:0]     row_o,
  output logic                              act_o,
  input  wire                               adv_i,
  input  wire                               target_i,
  input  wire  gsse_pkg::token_t            tok_i,
  output gsse_pkg::token_t                  tok_o
);

  logic [gsse_pkg::VAR_BITS-1:0] row_q;
  logic                          act_q;
  gsse_pkg::token_t              tok_q, tok_d;
  logic                          par;

  // parity of row AND candidate
  assign par = ^(row_q & tok_i.x);

  always_comb begin
    tok_d    = tok_i;
    tok_d.ok = tok_i.ok & (~act_q | (par == target_i));
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      tok_q <= '0;
    end else begin
      if (clear_i) begin
        act_q     <= 1'b0;
        tok_q.vld <= 1'b0;
      end else begin
        if (load_i) begin
          act_q <= act_i;
        end
        if (adv_i) begin
          tok_q <= tok_d;
        end
      end
    end
  end

  assign row_o = row_q;
  assign act_o = act_q;
  assign tok_o = tok_q;

endmodule
`default_nettype wire

FILE: hdl/gsse_collect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsse_collect
// Result collector: keeps one match back so the final one can be tagged last.
// ----------------------------------------------------------------------------
module gsse_collect (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           adv_i,
  input  wire  gsse_pkg::token_t        tok_i,
  input  wire                           flush_i,
  input  wire                           out_ready_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  output logic [gsse_pkg::VAR_BITS-1:0] solution_o,
  output logic                          found_o,
  output logic                          last_o
);

  logic                          hold_v_q;
  logic [gsse_pkg::VAR_BITS-1:0] hold_x_q;
  logic                          ov_q;
  logic [gsse_pkg::VAR_BITS-1:0] sol_q;
  logic                          found_q;
  logic                          last_q;
  logic                          hit;

  assign free_o = ~ov_q | out_ready_i;
  assign hit    = adv_i & tok_i.vld & tok_i.ok;

  // payload
  always_ff @(posedge clk_i) begin
    if (hit) begin
      hold_x_q <= tok_i.x;
      if (hold_v_q) begin
        sol_q   <= hold_x_q;
        found_q <= 1'b1;
        last_q  <= 1'b0;
      end
    end else if (flush_i) begin
      sol_q   <= hold_v_q ? hold_x_q : '0;
      found_q <= hold_v_q;
      last_q  <= 1'b1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (hit) begin
        hold_v_q <= 1'b1;
        if (hold_v_q) begin
          ov_q <= 1'b1;
        end else if (out_ready_i) begin
          ov_q <= 1'b0;
        end
      end else if (flush_i) begin
        hold_v_q <= 1'b0;
        ov_q     <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign solution_o  = sol_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

FILE: hdl/gf2_system_solution_enumerator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_system_solution_enumerator_unit
// Collects GF(2) equation rows and lists every nonzero solution vector.
// ----------------------------------------------------------------------------
// Usage:
// - Rows come in on the input request channel (valid/ready), one per cycle
//   while idle. Each accepted row shifts into a chain of MAX_ROWS cells;
//   rows beyond MAX_ROWS are dropped.
// - A row with last_row set starts the solve. The input is not ready again
//   until the solve has fully drained.
// - Candidates 1 .. 2^var_count-1 enter the cell chain one per cycle unless
//   the output stalls; each cell checks its own row and passes the candidate
//   on. A candidate that clears all cells is a solution.
// - Results leave on the output request channel. One match is held back so
//   the final result can carry last_result; with no match a single result
//   with found=0, solution=0 and last_result=1 is sent.
// - A solve injects every candidate, waits in the drain state for the final
//   candidate to leave the chain, then flushes the held or empty result.
// - When the receiver stalls, the whole chain freezes; nothing is lost.
// - Reset empties the chain, sets var_count = 3 and target_bit = 0.
// - Configuration writes (cfg_we_i) take effect at once; write only when idle.
// ----------------------------------------------------------------------------
module gf2_system_solution_enumerator_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [gsse_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [gsse_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [gsse_pkg::VAR_BITS-1:0]       in_row_mask_i,
  input  wire                                 in_last_row_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [gsse_pkg::VAR_BITS-1:0]       out_solution_o,
  output logic                                out_found_o,
  output logic                                out_last_result_o
);

  localparam int unsigned NR = gsse_pkg::MAX_ROWS;
  localparam int unsigned VB = gsse_pkg::VAR_BITS;
  localparam logic [VB-1:0] ONE_X = VB'(1);

  // controller states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;  // injecting candidates
  localparam logic [1:0] ST_DRAIN = 2'd2;  // waiting for final candidate
  localparam logic [1:0] ST_FLUSH = 2'd3;  // emit held / empty result

  logic [1:0] st_q, st_d;

  // config registers
  logic [gsse_pkg::CFG_DATA_W-1:0] var_count_q;
  logic                            target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= gsse_pkg::VAR_COUNT_RST;
      target_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gsse_pkg::REG_VAR_COUNT:  var_count_q <= cfg_data_i;
        gsse_pkg::REG_TARGET_BIT: target_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp variable count, derive top candidate
  logic [gsse_pkg::CFG_DATA_W-1:0] vars;
  logic [VB:0]                     lim;
  logic [VB-1:0]                   x_top;

  assign vars  = (var_count_q > gsse_pkg::CFG_DATA_W'(VB)) ?
                 gsse_pkg::CFG_DATA_W'(VB) : var_count_q;
  assign lim   = (VB+1)'(1) << vars;
  assign x_top = lim[VB-1:0] - ONE_X;  // wraps to all ones at full width

  // candidate generator
  logic [VB-1:0]    x_q;
  gsse_pkg::token_t inj;
  logic             inj_end;
  logic             adv;
  logic             free;
  logic             flush_go;
  logic             clear;

  assign inj_end  = (x_q == x_top) | (vars == '0);
  assign inj.vld  = (st_q == ST_RUN);
  assign inj.x    = x_q;
  assign inj.ok   = (vars != '0);
  assign inj.last = inj_end;

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE) begin
      x_q <= ONE_X;
    end else if (st_q == ST_RUN && adv) begin
      x_q <= x_q + ONE_X;
    end
  end

  // cell chain
  logic [VB-1:0]    row_chain [NR+1];
  logic             act_chain [NR+1];
  gsse_pkg::token_t tok_chain [NR+1];
  logic             load;
  logic             in_acc;
  logic             full;

  assign row_chain[0] = in_row_mask_i;
  assign act_chain[0] = 1'b1;
  assign tok_chain[0] = inj;
  assign full         = act_chain[NR];

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign load       = in_acc & ~full;
  assign adv        = free & ((st_q == ST_RUN) | (st_q == ST_DRAIN));
  assign flush_go   = (st_q == ST_FLUSH) & free;
  assign clear      = flush_go;

  for (genvar g = 0; g < NR; g++) begin : g_cell
    gsse_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (load),
      .clear_i  (clear),
      .row_i    (row_chain[g]),
      .act_i    (act_chain[g]),
      .row_o    (row_chain[g+1]),
      .act_o    (act_chain[g+1]),
      .adv_i    (adv),
      .target_i (target_q),
      .tok_i    (tok_chain[g]),
      .tok_o    (tok_chain[g+1])
    );
  end

  gsse_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .tok_i       (tok_chain[NR]),
    .flush_i     (flush_go),
    .out_ready_i (out_ready_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .solution_o  (out_solution_o),
    .found_o     (out_found_o),
    .last_o      (out_last_result_o)
  );

  // controller
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc && in_last_row_i) st_d = ST_RUN;
      end
      ST_RUN: begin
        if (adv && inj_end) st_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (adv && tok_chain[NR].vld && tok_chain[NR].last) st_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (flush_go) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // checks
  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !tok_chain[NR].vld)
    else $error("stale candidate at chain end while idle");

  a_flush_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_go |=> (out_valid_o && out_last_result_o))
    else $error("flush did not present a final result");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_found_o) |-> (out_last_result_o && out_solution_o == '0))
    else $error("empty marker not tagged last");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> (x_q != '0))
    else $error("zero candidate injected");

endmodule
`default_nettype wire
